// ===== design/wsfr_pkg.sv =====
// Package for the WebSocket frame receiver.
// Holds the parser phase, event kinds, header constants and the structs between modules.
// No dependencies.
package wsfr_pkg;

   localparam int LenW   = 64;
   localparam int KeyW   = 32;
   localparam int LimitW = 16;

   localparam logic [3:0] OPC_MASK_LOW = 4'h8;   // close opcode
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_DROP  = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_HDR0    = 7'b0000001,
      PH_HDR1    = 7'b0000010,
      PH_EXTLEN  = 7'b0000100,
      PH_MASK    = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_SKIP    = 7'b0100000,
      PH_CLOSED  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   typedef struct packed {
      logic closed;
   } status_type;

endpackage

// ===== design/wsfr_parser.sv =====
// Frame parser: header phases, length and key capture, unmasking and skip counting.
// One byte per step; result is combinational from the stepped byte and parser state.
// Depends on wsfr_pkg.
module wsfr_parser import wsfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        in_byte,
   input  logic [LimitW-1:0] payload_limit,
   output result_type        res,
   output status_type        status
);

   phase_type         phase_ff, phase_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              mask_ff, mask_in;
   logic              close_pend_ff, close_pend_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [KeyW-1:0]   key_ff, key_in;
   logic [1:0]        pos_ff, pos_in;
   logic              len_done;
   logic              hdr_done;
   logic [7:0]        key_byte;

   assign key_byte = key_ff[{pos_ff, 3'b000} +: 8];

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      mask_in       = mask_ff;
      close_pend_in = close_pend_ff;
      len_in        = len_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      len_done      = 1'b0;
      hdr_done      = 1'b0;
      res           = '0;
      if (step) begin
         unique case (phase_ff)
            PH_HDR0: begin
               close_pend_in = (in_byte[3:0] == OPC_MASK_LOW);
               phase_in      = PH_HDR1;
            end
            PH_HDR1: begin
               if (close_pend_ff) begin
                  phase_in = PH_CLOSED;
                  res      = '{valid: 1'b1, kind: KIND_CLOSE, data: 8'd0, last: 1'b1};
               end else begin
                  mask_in = in_byte[7];
                  len_in  = '0;
                  if (in_byte[6:0] == LEN_EXT16) begin
                     phase_in = PH_EXTLEN;
                     cnt_in   = EXT16_BYTES;
                  end else if (in_byte[6:0] == LEN_EXT64) begin
                     phase_in = PH_EXTLEN;
                     cnt_in   = EXT64_BYTES;
                  end else begin
                     len_in   = LenW'(in_byte[6:0]);
                     len_done = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               len_in = {len_ff[LenW-9:0], in_byte};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  len_done = 1'b1;
               end
            end
            PH_MASK: begin
               key_in = {in_byte, key_ff[KeyW-1:8]};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               pos_in = pos_ff + 2'd1;
               len_in = len_ff - LenW'(1);
               res    = '{valid: 1'b1, kind: KIND_BYTE, data: in_byte ^ key_byte,
                          last: (len_ff == LenW'(1))};
               if (len_ff == LenW'(1)) begin
                  phase_in = PH_HDR0;
               end
            end
            PH_SKIP: begin
               len_in = len_ff - LenW'(1);
               if (len_ff == LenW'(1)) begin
                  phase_in = PH_HDR0;
                  res      = '{valid: 1'b1, kind: KIND_DROP, data: 8'd0, last: 1'b1};
               end
            end
            PH_CLOSED: begin
               phase_in = PH_CLOSED;
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
      // length known: key follows or header is complete
      if (len_done) begin
         key_in = '0;
         if (mask_in) begin
            phase_in = PH_MASK;
            cnt_in   = KEY_BYTES;
         end else begin
            hdr_done = 1'b1;
         end
      end
      if (hdr_done) begin
         pos_in = '0;
         cnt_in = '0;
         if (len_in == '0) begin
            phase_in = PH_HDR0;
            res      = '{valid: 1'b1, kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
         end else if ((|len_in[LenW-1:LimitW]) || (len_in[LimitW-1:0] > payload_limit)) begin
            phase_in = PH_SKIP;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         cnt_ff        <= '0;
         mask_ff       <= 1'b0;
         close_pend_ff <= 1'b0;
         len_ff        <= '0;
         key_ff        <= '0;
         pos_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         mask_ff       <= mask_in;
         close_pend_ff <= close_pend_in;
         len_ff        <= len_in;
         key_ff        <= key_in;
         pos_ff        <= pos_in;
      end
   end

   assign status.closed = (phase_ff == PH_CLOSED);

endmodule

// ===== design/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver: input register, parser, result register, limit.
// Depends on wsfr_pkg and wsfr_parser.
//
//   channel | direction | payload                                      | handshake
//   req     | in        | req_in_byte                                  | req_valid / req_ready
//   rsp     | out       | rsp_event_kind, rsp_out_byte, rsp_last_of_frame | rsp_valid / rsp_ready
//   csr     | in        | csr_payload_limit                            | csr_valid / csr_ready
//
// One item per cycle sustained while rsp is not stalled; an item's result goes from the input
// register through the parser into the result register and is offered on rsp from there.
// Synchronous active-high reset; limit resets to 65535, csr_ready is always high.
// A stalled rsp holds the result register and the item in the input register behind it;
// req_ready falls once both are occupied.
// After a close frame every later item is taken and discarded until reset.
module websocket_frame_receiver import wsfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_event_kind,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_frame,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LimitW-1:0] csr_payload_limit
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   logic [LimitW-1:0] limit_ff;
   logic              step;
   result_type        res;
   status_type        status;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   // step with a result only when the result register is free or draining
   wsfr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .in_byte       (in_byte_ff),
      .payload_limit (limit_ff),
      .res           (res),
      .status        (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= '1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_payload_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_ff.kind;
   assign rsp_out_byte      = out_ff.data;
   assign rsp_last_of_frame = out_ff.last;

   a_event_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != KIND_BYTE) |-> rsp_last_of_frame && (rsp_out_byte == 8'd0))
      else $error("event result without last flag or with non-zero byte");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      status.closed |=> status.closed)
      else $error("receiver left closed state without reset");

   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      status.closed |-> !res.valid)
      else $error("result produced after close");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

endmodule

// ===== tb/tb_websocket_frame_receiver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_receiver: a directed table, then random frames.
// It predicts the decoder's events in SV and checks every rsp item in order.
// Depends on wsfr_pkg and the design sources.
module tb_websocket_frame_receiver import wsfr_pkg::*; ();

   localparam int          NUM_PHASES      = 9;
   localparam int          ITEMS_PER_PHASE = 180;
   localparam int          PRESSURE_PHASE  = 7;
   localparam int          LONG_HOLD       = 400;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int          DIRECTED_ROWS   = 28;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } ws_event_type;

   typedef enum logic {ROW_BYTE, ROW_LIMIT} row_op_type;

   typedef struct packed {
      row_op_type   op;
      logic [15:0]  value;
      logic         typed;
      logic         has_ev;
      ws_event_type ev;
   } directed_row_type;

   localparam ws_event_type NO_EVENT = '{KIND_BYTE, 8'h00, 1'b0};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_in_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_event_kind;
   logic [7:0]        rsp_out_byte;
   logic              rsp_last_of_frame;
   logic              csr_valid;
   logic              csr_ready;
   logic [LimitW-1:0] csr_payload_limit;

   // decoder state as predicted
   phase_type   ph;
   logic [3:0]  hdr_left;
   logic        masked;
   logic [63:0] flen;
   logic [31:0] key;
   logic [63:0] pos;
   logic        closed;
   logic        close_next;
   logic [15:0] lim;

   ws_event_type pending_events[$];
   logic [7:0]   wire_bytes[$];
   int           mismatches;
   int unsigned  cycle_count;
   int           idle_pct;
   int           stall_pct;
   bit           calm;
   bit           hold_request;
   logic [15:0]  phase_limits [NUM_PHASES];

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_BYTE,  16'h0081, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0000, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1}},
      '{ROW_BYTE,  16'h0082, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0001, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h00FF, 1'b1, 1'b1, '{KIND_BYTE, 8'hFF, 1'b1}},
      '{ROW_BYTE,  16'h0081, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0082, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h00A5, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h005A, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h00FF, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0000, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0000, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h00FF, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0089, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h007E, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0000, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0000, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1}},
      '{ROW_LIMIT, 16'h0001, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0082, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0002, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0011, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0022, 1'b1, 1'b1, '{KIND_DROP, 8'h00, 1'b1}},
      '{ROW_LIMIT, 16'h0002, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0082, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0002, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h00AA, 1'b1, 1'b1, '{KIND_BYTE, 8'hAA, 1'b0}},
      // limit drops to zero with the header already done
      '{ROW_LIMIT, 16'h0000, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE,  16'h0055, 1'b1, 1'b1, '{KIND_BYTE, 8'h55, 1'b1}}
   };

   websocket_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_payload_limit (csr_payload_limit)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit finish_header(output ws_event_type ev);
      pos      = '0;
      hdr_left = '0;
      ev       = '{KIND_EMPTY, 8'h00, 1'b1};
      if (flen == 0) begin
         ph = PH_HDR0;
         return 1'b1;
      end
      ph = (flen > 64'(lim)) ? PH_SKIP : PH_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic bit length_known(output ws_event_type ev);
      ev  = NO_EVENT;
      key = '0;
      if (masked) begin
         ph       = PH_MASK;
         hdr_left = KEY_BYTES;
         return 1'b0;
      end
      return finish_header(ev);
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output ws_event_type ev);
      logic       last;
      logic [7:0] k;
      logic [1:0] slot;
      ev = NO_EVENT;
      if (closed || ph == PH_CLOSED)
         return 1'b0;
      case (ph)
         PH_HDR0: begin
            close_next = (b[3:0] == OPC_MASK_LOW);
            ph         = PH_HDR1;
            return 1'b0;
         end
         PH_HDR1: begin
            if (close_next) begin
               closed = 1'b1;
               ph     = PH_CLOSED;
               ev     = '{KIND_CLOSE, 8'h00, 1'b1};
               return 1'b1;
            end
            masked = b[7];
            flen   = '0;
            if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
               ph       = PH_EXTLEN;
               hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               return 1'b0;
            end
            flen = 64'(b[6:0]);
            return length_known(ev);
         end
         PH_EXTLEN: begin
            flen     = {flen[55:0], b};
            hdr_left = hdr_left - 4'd1;
            if (hdr_left != 0)
               return 1'b0;
            return length_known(ev);
         end
         PH_MASK: begin
            slot     = 2'(KEY_BYTES - hdr_left);
            key      = key | (32'(b) << (8 * slot));
            hdr_left = hdr_left - 4'd1;
            if (hdr_left != 0)
               return 1'b0;
            return finish_header(ev);
         end
         PH_PAYLOAD: begin
            k    = 8'(key >> (8 * pos[1:0]));
            last = (pos == flen - 64'd1);
            pos  = pos + 64'd1;
            if (last)
               ph = PH_HDR0;
            ev = '{KIND_BYTE, b ^ k, last};
            return 1'b1;
         end
         PH_SKIP: begin
            last = (pos == flen - 64'd1);
            pos  = pos + 64'd1;
            if (last) begin
               ph = PH_HDR0;
               ev = '{KIND_DROP, 8'h00, 1'b1};
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            ph = PH_HDR0;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic put_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                           input ws_event_type typed_ev);
      ws_event_type ev;
      bit           got;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      got = decode_byte(b, ev);
      if (typed) begin
         if (typed_has)
            pending_events.insert(pending_events.size(), typed_ev);
      end else if (got) begin
         pending_events.insert(pending_events.size(), ev);
      end
   endtask

   // only with nothing in flight
   task automatic write_limit(input logic [15:0] v);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_payload_limit <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lim = v;
   endtask

   task automatic build_frame();
      logic [7:0]  op;
      logic [63:0] len;
      logic        with_key;
      int          sel;
      op = 8'($urandom);
      if (op[3:0] == OPC_MASK_LOW)
         op[3:0] = 4'h2;
      with_key = 1'($urandom);
      sel      = $urandom_range(0, 99);
      wire_bytes.insert(wire_bytes.size(), op);
      if (sel < 72) begin
         len = (sel < 55) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(13, 125));
         wire_bytes.insert(wire_bytes.size(), {with_key, len[6:0]});
      end else if (sel < 88) begin
         len = 64'($urandom_range(0, 320));
         wire_bytes.insert(wire_bytes.size(), {with_key, LEN_EXT16});
         wire_bytes.insert(wire_bytes.size(), len[15:8]);
         wire_bytes.insert(wire_bytes.size(), len[7:0]);
      end else begin
         len = 64'($urandom_range(0, 160));
         wire_bytes.insert(wire_bytes.size(), {with_key, LEN_EXT64});
         for (int i = 7; i >= 0; i--)
            wire_bytes.insert(wire_bytes.size(), len[8*i +: 8]);
      end
      if (with_key)
         repeat (4) wire_bytes.insert(wire_bytes.size(), 8'($urandom));
      repeat (int'(len)) wire_bytes.insert(wire_bytes.size(), 8'($urandom));
   endtask

   // receiver side
   initial begin
      int          hold_left;
      int          stall_left;
      int unsigned tick;
      rsp_ready  = 1'b0;
      hold_left  = 0;
      stall_left = 0;
      tick       = 0;
      stall_pct  = 10;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 256 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      ws_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item at cycle %0d: kind %0d byte %02h last %0b",
                        cycle_count, rsp_event_kind, rsp_out_byte, rsp_last_of_frame);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind || rsp_out_byte !== want.data ||
                rsp_last_of_frame !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: expected %0d/%02h/%0b got %0d/%02h/%0b",
                           cycle_count, want.kind, want.data, want.last,
                           rsp_event_kind, rsp_out_byte, rsp_last_of_frame);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [7:0] op;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'h00;
      csr_valid         = 1'b0;
      csr_payload_limit = '0;
      mismatches        = 0;
      cycle_count       = 0;
      idle_pct          = 10;
      calm              = 1'b0;
      hold_request      = 1'b0;
      ph                = PH_HDR0;
      hdr_left          = '0;
      masked            = 1'b0;
      flen              = '0;
      key               = '0;
      pos               = '0;
      closed            = 1'b0;
      close_next        = 1'b0;
      lim               = 16'hFFFF;
      phase_limits      = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 40)),
                            16'd125, 16'd126, 16'($urandom), 16'hFFFF,
                            16'($urandom_range(200, 65535))};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_LIMIT)
            write_limit(directed_rows[i].value);
         else
            put_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                     directed_rows[i].has_ev, directed_rows[i].ev);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limits[p]);
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 30;
         endcase
         if (p == PRESSURE_PHASE) begin
            idle_pct     = 0;
            hold_request = 1'b1;
         end
         if (p == NUM_PHASES - 1)
            calm = 1'b1;
         repeat (ITEMS_PER_PHASE) begin
            if (wire_bytes.size() == 0)
               build_frame();
            put_byte(wire_bytes.pop_front(), 1'b0, 1'b0, NO_EVENT);
         end
      end
      while (wire_bytes.size() != 0)
         put_byte(wire_bytes.pop_front(), 1'b0, 1'b0, NO_EVENT);

      // close frame, then bytes that must all be swallowed
      op = {4'($urandom), OPC_MASK_LOW};
      put_byte(op, 1'b0, 1'b0, NO_EVENT);
      put_byte(8'($urandom), 1'b0, 1'b0, NO_EVENT);
      repeat (12) put_byte(8'($urandom), 1'b0, 1'b0, NO_EVENT);
      req_valid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
design/wsfr_pkg.sv
design/wsfr_parser.sv
design/websocket_frame_receiver.sv
tb/tb_websocket_frame_receiver.sv
